// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the biquad filter RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ANY(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bqd_pkg.sv =====
// Shared constants and types for the biquad IIR filter.
// Used by the register block, the digit-serial multiplier and the top level.
package bqd_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_BITS      = 32;
    localparam int COEF_FRAC_BITS = 28;
    localparam int ACC_BITS       = 64;

    localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

    localparam int DIGITS    = (SAMPLE_BITS + 1) / 2;
    localparam int MOP_BITS  = 2 * DIGITS;
    localparam int CNT_BITS  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int PROD_BITS = COEF_BITS + 1 + MOP_BITS;

    localparam int REG_COUNT  = 5;
    localparam int IDX_BITS   = 3;
    localparam int ADDR_BITS  = IDX_BITS + 2;
    localparam int PDATA_BITS = 32;

    localparam logic signed [COEF_BITS-1:0] COEF_UNITY =
        COEF_BITS'(64'sd1 <<< COEF_FRAC_BITS);
    localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
        ACC_BITS'(64'sd1 <<< (COEF_FRAC_BITS - 1));
    localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [IDX_BITS-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] b0;
        logic signed [COEF_BITS-1:0] b1;
        logic signed [COEF_BITS-1:0] b2;
        logic signed [COEF_BITS-1:0] a1;
        logic signed [COEF_BITS-1:0] a2;
    } coef_set_t;

    typedef struct packed {
        logic clear;
        logic step;
        logic last;
    } mult_ctrl_t;

endpackage

// ===== rtl/bqd_cfg_regs.sv =====
// APB-style register block holding the five biquad coefficients.
// Depends on bqd_pkg for the register map and the coefficient struct.
module bqd_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bqd_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [bqd_pkg::PDATA_BITS-1:0]    pwdata,
    output logic [bqd_pkg::PDATA_BITS-1:0]    prdata,
    output logic                              pready,
    output bqd_pkg::coef_set_t                coefs
);
    import bqd_pkg::*;

    coef_set_t              coef_reg;
    coef_set_t              coef_next;
    logic [IDX_BITS-1:0]    idx;
    logic                   wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_BITS-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign coefs  = coef_reg;

    always_comb begin
        coef_next = coef_reg;
        if (wr_en) begin
            case (idx)
                REG_B0:  coef_next.b0 = COEF_BITS'(pwdata);
                REG_B1:  coef_next.b1 = COEF_BITS'(pwdata);
                REG_B2:  coef_next.b2 = COEF_BITS'(pwdata);
                REG_A1:  coef_next.a1 = COEF_BITS'(pwdata);
                REG_A2:  coef_next.a2 = COEF_BITS'(pwdata);
                default: coef_next = coef_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_B0:  prdata = PDATA_BITS'(coef_reg.b0);
            REG_B1:  prdata = PDATA_BITS'(coef_reg.b1);
            REG_B2:  prdata = PDATA_BITS'(coef_reg.b2);
            REG_A1:  prdata = PDATA_BITS'(coef_reg.a1);
            REG_A2:  prdata = PDATA_BITS'(coef_reg.a2);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg.b0 <= COEF_UNITY;
            coef_reg.b1 <= '0;
            coef_reg.b2 <= '0;
            coef_reg.a1 <= '0;
            coef_reg.a2 <= '0;
        end else begin
            coef_reg <= coef_next;
        end
    end

endmodule

// ===== rtl/bqd_digit_mult.sv =====
// Digit-serial signed multiplier: one radix-4 digit of the sample per cycle while
// step is set, against a parallel coefficient. Uses bqd_pkg widths and controls.
module bqd_digit_mult (
    input  logic                                   aclk,
    input  bqd_pkg::mult_ctrl_t                    ctrl,
    input  logic [1:0]                             digit,
    input  logic signed [bqd_pkg::COEF_BITS-1:0]   coef,
    output logic signed [bqd_pkg::ACC_BITS-1:0]    product
);
    import bqd_pkg::*;

    localparam int ADD_BITS = COEF_BITS + 3;

    logic signed [COEF_BITS:0]    hi_reg;
    logic signed [COEF_BITS:0]    hi_next;
    logic [MOP_BITS-1:0]          lo_reg;
    logic [MOP_BITS-1:0]          lo_next;
    logic signed [ADD_BITS-1:0]   c_ext;
    logic signed [ADD_BITS-1:0]   t0;
    logic signed [ADD_BITS-1:0]   t1;
    logic signed [ADD_BITS-1:0]   sum;
    logic signed [PROD_BITS-1:0]  full;

    always_comb begin
        c_ext = ADD_BITS'(coef);
        t0    = digit[0] ? c_ext : '0;
        t1    = digit[1] ? (c_ext <<< 1) : '0;
        // The top digit carries the sign bit of the sample with negative weight.
        if (ctrl.last) begin
            t1 = -t1;
        end
        sum     = ADD_BITS'(hi_reg) + t0 + t1;
        hi_next = sum[ADD_BITS-1:2];
        lo_next = {sum[1:0], lo_reg[MOP_BITS-1:2]};
    end

    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            hi_reg <= '0;
        end else if (ctrl.step) begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign full    = {hi_reg, lo_reg};
    assign product = ACC_BITS'(full);

endmodule

// ===== rtl/biquad_iir_filter_top.sv =====
// Biquad IIR section, transposed direct form II, with digit-serial multipliers.
// Depends on bqd_pkg, bqd_cfg_regs, bqd_digit_mult and assert_macros.svh.
//
// Usage:
// Samples arrive on the s_ stream channel (s_tdata holds sample_in) and filtered
// samples leave on the m_ stream channel (m_tdata holds sample_out, m_tuser the
// clip flag). Coefficients b0, b1, b2, a1, a2 are written over the APB-style
// port at byte addresses 0, 4, 8, 12 and 16 while no sample is in flight.
// One sample is processed at a time. Three multipliers take the input sample
// two bits per cycle against b0, b1 and b2; then two of them take the output
// sample against a1 and a2. After a sample is accepted the block steps through
// the input pass (ST_MUL_X), ST_ACC, ST_RND and ST_SATY, which loads the output
// register and raises m_tvalid; then the output pass (ST_MUL_Y), ST_UPD1 and
// ST_UPD2 update the delay accumulators before s_tready returns in ST_IDLE.
// The result sits in an output register, so a stalled receiver only holds the
// block when the next result is ready and the previous one is still waiting.
// Reset restores unity-gain coefficients, clears both delay accumulators and
// empties the output register.
`include "assert_macros.svh"

module biquad_iir_filter_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bqd_pkg::TDATA_BITS-1:0]      s_tdata,  // [23:0] sample_in
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bqd_pkg::TDATA_BITS-1:0]      m_tdata,  // [23:0] sample_out
    output logic [0:0]                          m_tuser,  // [0] clipped
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bqd_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [bqd_pkg::PDATA_BITS-1:0]      pwdata,
    output logic [bqd_pkg::PDATA_BITS-1:0]      prdata,
    output logic                                pready
);
    import bqd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_ACC,
        ST_RND,
        ST_SATY,
        ST_MUL_Y,
        ST_UPD1,
        ST_UPD2
    } state_t;

    state_t                        state_reg, state_next;
    logic [CNT_BITS-1:0]           cnt_reg, cnt_next;
    logic [MOP_BITS-1:0]           mop_reg, mop_next;
    logic signed [ACC_BITS-1:0]    acc_reg, acc_next;
    logic signed [ACC_BITS-1:0]    tmp_reg, tmp_next;
    logic signed [ACC_BITS-1:0]    p1x_reg, p1x_next;
    logic signed [ACC_BITS-1:0]    p2x_reg, p2x_next;
    logic signed [ACC_BITS-1:0]    d1_reg, d1_next;
    logic signed [ACC_BITS-1:0]    d2_reg, d2_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_BITS-1:0]        y_reg, y_next;
    logic                          clip_reg, clip_next;

    coef_set_t                     coefs;
    mult_ctrl_t                    mctrl;
    logic signed [COEF_BITS-1:0]   coef1;
    logic signed [COEF_BITS-1:0]   coef2;
    logic signed [ACC_BITS-1:0]    prod0;
    logic signed [ACC_BITS-1:0]    prod1;
    logic signed [ACC_BITS-1:0]    prod2;
    logic signed [SAMPLE_BITS-1:0] x_in;
    logic signed [ACC_BITS-1:0]    ysh;
    logic signed [SAMPLE_BITS-1:0] y_sat;
    logic                          y_over;
    logic                          last_digit;

    function automatic logic signed [ACC_BITS-1:0] sat_add(
        input logic signed [ACC_BITS-1:0] a,
        input logic signed [ACC_BITS-1:0] b
    );
        logic signed [ACC_BITS:0] s;
        s = {a[ACC_BITS-1], a} + {b[ACC_BITS-1], b};
        if (s[ACC_BITS] != s[ACC_BITS-1]) begin
            return s[ACC_BITS] ? ACC_MIN : ACC_MAX;
        end
        return s[ACC_BITS-1:0];
    endfunction

    bqd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coefs   (coefs)
    );

    assign coef1 = (state_reg == ST_MUL_Y) ? coefs.a1 : coefs.b1;
    assign coef2 = (state_reg == ST_MUL_Y) ? coefs.a2 : coefs.b2;

    bqd_digit_mult u_mult0 (
        .aclk    (aclk),
        .ctrl    (mctrl),
        .digit   (mop_reg[1:0]),
        .coef    (coefs.b0),
        .product (prod0)
    );

    bqd_digit_mult u_mult1 (
        .aclk    (aclk),
        .ctrl    (mctrl),
        .digit   (mop_reg[1:0]),
        .coef    (coef1),
        .product (prod1)
    );

    bqd_digit_mult u_mult2 (
        .aclk    (aclk),
        .ctrl    (mctrl),
        .digit   (mop_reg[1:0]),
        .coef    (coef2),
        .product (prod2)
    );

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = TDATA_BITS'(y_reg);
    assign m_tuser    = clip_reg;
    assign x_in       = s_tdata[SAMPLE_BITS-1:0];
    assign last_digit = (cnt_reg == CNT_BITS'(DIGITS - 1));

    always_comb begin
        ysh    = acc_reg >>> COEF_FRAC_BITS;
        y_over = !((&ysh[ACC_BITS-1:SAMPLE_BITS-1]) || (~|ysh[ACC_BITS-1:SAMPLE_BITS-1]));
        if (y_over) begin
            y_sat = ysh[ACC_BITS-1] ? SAMPLE_MIN : SAMPLE_MAX;
        end else begin
            y_sat = ysh[SAMPLE_BITS-1:0];
        end
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        mop_next      = mop_reg;
        acc_next      = acc_reg;
        tmp_next      = tmp_reg;
        p1x_next      = p1x_reg;
        p2x_next      = p2x_reg;
        d1_next       = d1_reg;
        d2_next       = d2_reg;
        y_next        = y_reg;
        clip_next     = clip_reg;
        m_tvalid_next = m_tvalid_reg;
        mctrl.clear   = 1'b0;
        mctrl.step    = 1'b0;
        mctrl.last    = last_digit;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    mop_next    = MOP_BITS'(x_in);
                    cnt_next    = '0;
                    mctrl.clear = 1'b1;
                    state_next  = ST_MUL_X;
                end
            end
            ST_MUL_X: begin
                mctrl.step = 1'b1;
                mop_next   = {2'b00, mop_reg[MOP_BITS-1:2]};
                cnt_next   = cnt_reg + 1'b1;
                if (last_digit) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                acc_next   = sat_add(prod0, d1_reg);
                p1x_next   = prod1;
                p2x_next   = prod2;
                state_next = ST_RND;
            end
            ST_RND: begin
                acc_next   = sat_add(acc_reg, ROUND_HALF);
                state_next = ST_SATY;
            end
            ST_SATY: begin
                if (!m_tvalid_reg || m_tready) begin
                    y_next        = y_sat;
                    clip_next     = y_over;
                    m_tvalid_next = 1'b1;
                    mop_next      = MOP_BITS'(y_sat);
                    cnt_next      = '0;
                    mctrl.clear   = 1'b1;
                    state_next    = ST_MUL_Y;
                end
            end
            ST_MUL_Y: begin
                mctrl.step = 1'b1;
                mop_next   = {2'b00, mop_reg[MOP_BITS-1:2]};
                cnt_next   = cnt_reg + 1'b1;
                if (last_digit) begin
                    state_next = ST_UPD1;
                end
            end
            ST_UPD1: begin
                tmp_next   = p1x_reg - prod1;
                state_next = ST_UPD2;
            end
            ST_UPD2: begin
                d1_next    = sat_add(tmp_reg, d2_reg);
                d2_next    = p2x_reg - prod2;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            d1_reg       <= '0;
            d2_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            d1_reg       <= d1_next;
            d2_reg       <= d2_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        mop_reg  <= mop_next;
        acc_reg  <= acc_next;
        tmp_reg  <= tmp_next;
        p1x_reg  <= p1x_next;
        p2x_reg  <= p2x_next;
        y_reg    <= y_next;
        clip_reg <= clip_next;
    end

    `ASSERT_RST(a_accept_starts_mul, aclk, aresetn,
        (s_tvalid && s_tready) |=> (state_reg == ST_MUL_X), "Accepted request did not start")
    `ASSERT_RST(a_valid_from_saty, aclk, aresetn,
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_SATY), "Result raised outside output stage")
    `ASSERT_RST(a_hold_on_stall, aclk, aresetn,
        (state_reg == ST_SATY && m_tvalid_reg && !m_tready) |=> (state_reg == ST_SATY),
        "Output stage advanced over a pending result")
    `ASSERT_ANY(a_reset_empties, aclk,
        !aresetn |=> !m_tvalid_reg, "Output register not empty after reset")

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for biquad_iir_filter_top: predicts every filtered sample and
// compares it with the stream output. Depends on bqd_pkg and the filter RTL only.
`timescale 1ns / 1ps

module tb_top;
    import bqd_pkg::*;

    localparam int SAMPLE_COUNT = 1800;
    localparam int SETTLE_CYCLES = 2 * DIGITS + 10;
    localparam int PRINT_CAP = 100;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          clipped;
    } filt_result_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_BITS-1:0]  s_tdata;   // [23:0] sample_in
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_BITS-1:0]  m_tdata;   // [23:0] sample_out
    logic [0:0]             m_tuser;   // [0] clipped
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [ADDR_BITS-1:0]   paddr;
    logic [PDATA_BITS-1:0]  pwdata;
    logic [PDATA_BITS-1:0]  prdata;
    logic                   pready;

    coef_set_t                   taps;
    logic signed [ACC_BITS-1:0]  delay_one;
    logic signed [ACC_BITS-1:0]  delay_two;
    filt_result_t                pending_outputs[$];
    int                          error_count;
    bit                          steady;

    biquad_iir_filter_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #100ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 40) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 4);
        end else if (r < 97) begin
            return $urandom_range(5, 40);
        end
        return $urandom_range(41, 200);
    endfunction

    function automatic logic signed [ACC_BITS-1:0] clamp_acc(input logic [ACC_BITS:0] s);
        if (s[ACC_BITS] != s[ACC_BITS-1]) begin
            return s[ACC_BITS] ? ACC_MIN : ACC_MAX;
        end
        return s[ACC_BITS-1:0];
    endfunction

    function automatic logic signed [ACC_BITS-1:0] sat_add(
        input logic signed [ACC_BITS-1:0] a,
        input logic signed [ACC_BITS-1:0] b
    );
        return clamp_acc({a[ACC_BITS-1], a} + {b[ACC_BITS-1], b});
    endfunction

    function automatic logic signed [ACC_BITS-1:0] sat_sub(
        input logic signed [ACC_BITS-1:0] a,
        input logic signed [ACC_BITS-1:0] b
    );
        return clamp_acc({a[ACC_BITS-1], a} - {b[ACC_BITS-1], b});
    endfunction

    task automatic predict_filtered_sample(input logic signed [SAMPLE_BITS-1:0] x);
        logic signed [ACC_BITS-1:0] xs, ys, acc, hi, lo;
        logic signed [ACC_BITS-1:0] b0, b1, b2, a1, a2;
        filt_result_t res;
        xs = x;
        b0 = $signed(taps.b0);
        b1 = $signed(taps.b1);
        b2 = $signed(taps.b2);
        a1 = $signed(taps.a1);
        a2 = $signed(taps.a2);
        hi = SAMPLE_MAX;
        lo = SAMPLE_MIN;
        acc = sat_add(xs * b0, delay_one);
        acc = sat_add(acc, ROUND_HALF);
        ys = acc >>> COEF_FRAC_BITS;
        res.clipped = 1'b0;
        if (ys > hi) begin
            ys = hi;
            res.clipped = 1'b1;
        end else if (ys < lo) begin
            ys = lo;
            res.clipped = 1'b1;
        end
        delay_one = sat_add(sat_sub(xs * b1, ys * a1), delay_two);
        delay_two = sat_sub(xs * b2, ys * a2);
        res.sample = ys[SAMPLE_BITS-1:0];
        pending_outputs.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < PRINT_CAP) begin
            $display("%0t ns: %s mismatch, got %h, expected %h", $time, what, got, want);
        end
        error_count++;
    endtask

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata <= TDATA_BITS'($urandom);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= TDATA_BITS'(x);
        do @(posedge aclk); while (!s_tready);
        predict_filtered_sample(x);
    endtask

    task automatic apb_write(input logic [ADDR_BITS-1:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (reg_idx_t'(addr[ADDR_BITS-1:2]))
            REG_B0: taps.b0 = data;
            REG_B1: taps.b1 = data;
            REG_B2: taps.b2 = data;
            REG_A1: taps.a1 = data;
            REG_A2: taps.a2 = data;
            default: ;
        endcase
    endtask

    task automatic apb_release();
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic program_taps(input logic [31:0] b0, b1, b2, a1, a2);
        apb_write({REG_B0, 2'b00}, b0);
        apb_write({REG_B1, 2'b00}, b1);
        apb_write({REG_B2, 2'b00}, b2);
        apb_write({REG_A1, 2'b00}, a1);
        apb_write({REG_A2, 2'b00}, a2);
        apb_release();
    endtask

    // The block may still be busy after its last result, so let it settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(0, 9))
            0: return {1'b0, {31{1'b1}}};
            1: return {1'b1, {31{1'b0}}};
            2: return 32'd0;
            3: return COEF_UNITY;
            4: return -COEF_UNITY;
            5, 6: return $urandom;
            default: return $signed($urandom) >>> $urandom_range(2, 6);
        endcase
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return 0;
            3, 4: return SAMPLE_BITS'(int'($urandom_range(0, 511)) - 256);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic test_unity_passthrough();
        send_sample(0);
        send_sample(1);
        send_sample(-1);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(24'h555555);
        send_sample(24'hAAAAAA);
        send_sample(24'h000100);
        wait_idle();
    endtask

    // Writes beyond the last coefficient must leave the taps unchanged.
    task automatic test_unknown_registers();
        for (int k = REG_COUNT; k < 8; k++) begin
            apb_write(ADDR_BITS'(4 * k), 32'hFFFFFFFF);
        end
        apb_release();
        send_sample(SAMPLE_MAX);
        send_sample(-12345);
        send_sample(SAMPLE_MIN);
        wait_idle();
    endtask

    task automatic test_output_clipping();
        program_taps({1'b0, {31{1'b1}}}, {1'b1, {31{1'b0}}}, {1'b0, {31{1'b1}}},
                     {1'b0, {31{1'b1}}}, {1'b1, {31{1'b0}}});
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(1);
        send_sample(-1);
        send_sample(0);
        wait_idle();
        program_taps({1'b1, {31{1'b0}}}, 32'd0, 32'd0, 32'd0, 32'd0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(24'h000010);
        send_sample(-16);
        wait_idle();
    endtask

    // Poles on the unit circle make the output grow until it clips.
    task automatic test_feedback_growth();
        program_taps(COEF_UNITY, 32'd0, 32'd0, -(2 * COEF_UNITY), COEF_UNITY);
        send_sample(SAMPLE_MAX);
        send_sample(0);
        send_sample(0);
        send_sample(0);
        wait_idle();
    endtask

    task automatic test_random_filters();
        int sent;
        int phase_len;
        sent = 0;
        while (sent < SAMPLE_COUNT) begin
            program_taps(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef());
            steady = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(60, 160);
            for (int i = 0; i < phase_len; i++) begin
                send_sample(pick_sample());
            end
            sent += phase_len;
            wait_idle();
        end
        steady = 1'b0;
    endtask

    initial begin
        int hold;
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            hold = draw_gap();
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        filt_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_outputs.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, 32'd0);
            end else begin
                want = pending_outputs.pop_front();
                if (m_tdata[SAMPLE_BITS-1:0] !== want.sample) begin
                    report_mismatch("sample_out", m_tdata[SAMPLE_BITS-1:0], want.sample);
                end
                if (m_tuser[0] !== want.clipped) begin
                    report_mismatch("clipped", m_tuser[0], want.clipped);
                end
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        steady = 1'b0;
        taps = '{b0: COEF_UNITY, b1: '0, b2: '0, a1: '0, a2: '0};
        delay_one = '0;
        delay_two = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_unity_passthrough();
        test_unknown_registers();
        test_output_clipping();
        test_feedback_growth();
        test_random_filters();

        wait_idle();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
